// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/fib_fd_pkg.sv =====
// ----------------------------------------------------------------------------
// fib_fd_pkg
// Types and constants shared by the fast-doubling Fibonacci controller and datapath.
// ----------------------------------------------------------------------------
package fib_fd_pkg;

	localparam int unsigned INDEX_W = 8;
	localparam int unsigned VALUE_W = 63;
	localparam int unsigned PROD_W  = 64;
	localparam int unsigned OPND_W  = 32;
	localparam int unsigned BITSEL_W = 3;

	localparam logic [INDEX_W-1:0] FIB_LIMIT = 8'd92;
	localparam logic [INDEX_W-1:0] TRIVIAL_LIMIT = 8'd2;

	// Sub-step codes of one doubling iteration
	localparam logic [1:0] STEP_SQ_CUR  = 2'd0;
	localparam logic [1:0] STEP_SQ_PREV = 2'd1;
	localparam logic [1:0] STEP_CROSS   = 2'd2;
	localparam logic [1:0] STEP_UPDATE  = 2'd3;

	typedef struct packed {
		logic                load;
		logic                run;
		logic [1:0]          step;
		logic [BITSEL_W-1:0] bit_sel;
		logic                emit;
	} cmd_t;

	typedef struct packed {
		logic                skip;
		logic [BITSEL_W-1:0] top;
	} sts_t;

endpackage

// ===== src/fib_fd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fib_fd_ctrl
// Sequencer: accepts an index, walks its bits four sub-steps each, emits the word.
// ----------------------------------------------------------------------------
module fib_fd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  fib_fd_pkg::sts_t    sts,
	output fib_fd_pkg::cmd_t    cmd
);
	import fib_fd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]          state_q;
	logic [1:0]          step_q;
	logic [BITSEL_W-1:0] bit_q;
	logic                m_tvalid_q;
	logic                emit;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign emit     = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_comb begin
		cmd.load    = s_tvalid && s_tready;
		cmd.run     = (state_q == ST_RUN);
		cmd.step    = step_q;
		cmd.bit_sel = bit_q;
		cmd.emit    = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= STEP_SQ_CUR;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q <= STEP_SQ_CUR;
					bit_q  <= sts.top - 3'd1;
					state_q <= sts.skip ? ST_FIN : ST_RUN;
				end
				ST_RUN: begin
					step_q <= step_q + 2'd1;
					if (step_q == STEP_UPDATE) begin
						if (bit_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							bit_q <= bit_q - 3'd1;
						end
					end
				end
				ST_FIN: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/fib_fd_dp.sv =====
// ----------------------------------------------------------------------------
// fib_fd_dp
// Datapath: term pair registers, one shared 32x32 multiplier, sum and output word.
// ----------------------------------------------------------------------------
module fib_fd_dp (
	input  logic                clk,
	input  logic [7:0]          index,
	input  fib_fd_pkg::cmd_t    cmd,
	output fib_fd_pkg::sts_t    sts,
	output logic [62:0]         value,
	output logic                in_range
);
	import fib_fd_pkg::*;

	logic [INDEX_W-1:0]  n_q;
	logic [VALUE_W-1:0]  cur_q;
	logic [VALUE_W-1:0]  prev_q;
	logic [PROD_W-1:0]   sq_q;
	logic [PROD_W-1:0]   prod_q;
	logic [VALUE_W-1:0]  value_q;
	logic                in_range_q;
	logic                cur_bit;
	logic                valid_n;
	logic [PROD_W-1:0]   cross_w;
	logic [OPND_W-1:0]   opnd_a;
	logic [OPND_W-1:0]   opnd_b;
	logic [BITSEL_W-1:0] top;

	assign valid_n = (n_q < FIB_LIMIT);
	assign cur_bit = n_q[cmd.bit_sel];

	always_comb begin
		top = '0;
		for (int i = 1; i < 7; i++) begin
			if (n_q[i]) begin
				top = BITSEL_W'(i);
			end
		end
	end

	assign sts.top  = top;
	assign sts.skip = !valid_n || (n_q < TRIVIAL_LIMIT);

	// Operands stay below 2^32 for every index that reaches a doubling step
	always_comb begin
		if (cur_bit) begin
			cross_w = {1'b0, cur_q} + {prev_q, 1'b0};
		end else begin
			cross_w = {cur_q, 1'b0} - {1'b0, prev_q};
		end
		case (cmd.step)
			STEP_SQ_CUR: begin
				opnd_a = cur_q[OPND_W-1:0];
				opnd_b = cur_q[OPND_W-1:0];
			end
			STEP_SQ_PREV: begin
				opnd_a = prev_q[OPND_W-1:0];
				opnd_b = prev_q[OPND_W-1:0];
			end
			STEP_CROSS: begin
				opnd_a = cross_w[OPND_W-1:0];
				opnd_b = cur_bit ? cur_q[OPND_W-1:0] : prev_q[OPND_W-1:0];
			end
			default: begin
				opnd_a = '0;
				opnd_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= index;
			cur_q  <= VALUE_W'(1);
			prev_q <= VALUE_W'(1);
		end
		if (cmd.run) begin
			prod_q <= PROD_W'(opnd_a) * PROD_W'(opnd_b);
			case (cmd.step)
				STEP_SQ_PREV: begin
					sq_q <= prod_q;
				end
				STEP_CROSS: begin
					sq_q <= sq_q + prod_q;
				end
				STEP_UPDATE: begin
					if (cur_bit) begin
						prev_q <= sq_q[VALUE_W-1:0];
						cur_q  <= prod_q[VALUE_W-1:0];
					end else begin
						cur_q  <= sq_q[VALUE_W-1:0];
						prev_q <= prod_q[VALUE_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.emit) begin
			value_q    <= valid_n ? cur_q : '0;
			in_range_q <= valid_n;
		end
	end

	assign value    = value_q;
	assign in_range = in_range_q;

endmodule

// ===== src/fibonacci_fast_doubling.sv =====
// ----------------------------------------------------------------------------
// fibonacci_fast_doubling
// Fibonacci term f(n), f(0) = f(1) = 1, by fast doubling over the bits of n.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser        | tlast
//  s_      | in  | [7:0] index                   | -            | -
//  m_      | out | [62:0] value, [63] zero       | [0] in_range | -
//
//  Index 0, 1 or 92 and up skip the doubling steps and go straight to the output.
//  Otherwise the walk starts below the top set bit of n (position at most 6).
//  Each bit below the top takes four sub-steps on the one 32x32 multiplier.
//  One index in flight; the next is accepted once the result is in the output
//  register, even while that word waits on m_tready. arst_n clears control only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fibonacci_fast_doubling (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [62:0] value, [63] zero
	output logic [0:0]  m_tuser    // [0] in_range
);
	import fib_fd_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [62:0] value;
	logic        in_range;

	fib_fd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fib_fd_dp u_dp (
		.clk      (clk),
		.index    (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.value    (value),
		.in_range (in_range)
	);

	assign m_tdata = {1'b0, value};
	assign m_tuser = in_range;

	`ASSERT_IMPL(a_oor_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == 64'd0)
	`ASSERT_IMPL(a_inr_nonzero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[62:0] != 63'd0)
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule
